@@ hdl/weo_pkg.sv @@
package weo_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ATAN_IDX_W       = 5;

    localparam logic [15:0] RADIUS_RST       = 16'd1311;
    localparam logic [15:0] INV_AXLE_RST     = 16'd4491;
    localparam logic [17:0] STEPS_PER_S_RST  = 18'd8000;

    localparam logic [1:0] REG_RADIUS       = 2'd0;
    localparam logic [1:0] REG_INV_AXLE     = 2'd1;
    localparam logic [1:0] REG_STEPS_PER_S  = 2'd2;

    localparam logic signed [15:0] PI_Q13      = 16'sd25736;
    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [15:0] NEG_PI_Q13  = -16'sd25736;
    localparam logic [26:0]        TWO_PI_Q13  = 27'd51472;
    localparam logic signed [32:0] CORDIC_X0   = 33'sd652032874;
    localparam logic [3:0]         WRAP_TOP    = 4'd10;

    typedef struct packed {
        logic signed [16:0] sum;
        logic signed [16:0] diff;
    } weo_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRAVEL,
        ST_DPROD,
        ST_DTHETA,
        ST_LOADD,
        ST_CORDIC,
        ST_POSX,
        ST_POSY,
        ST_FSPD,
        ST_TRATE,
        ST_TRCAP,
        ST_WRAP,
        ST_DONE
    } weo_state_t;

    function automatic logic signed [32:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [32:0] v;
        unique case (idx)
            5'd0:    v = 33'sd843314857;
            5'd1:    v = 33'sd497837829;
            5'd2:    v = 33'sd263043837;
            5'd3:    v = 33'sd133525159;
            5'd4:    v = 33'sd67021687;
            5'd5:    v = 33'sd33543516;
            5'd6:    v = 33'sd16775851;
            5'd7:    v = 33'sd8388437;
            5'd8:    v = 33'sd4194283;
            5'd9:    v = 33'sd2097149;
            5'd10:   v = 33'sd1048576;
            5'd11:   v = 33'sd524288;
            5'd12:   v = 33'sd262144;
            5'd13:   v = 33'sd131072;
            5'd14:   v = 33'sd65536;
            5'd15:   v = 33'sd32768;
            5'd16:   v = 33'sd16384;
            5'd17:   v = 33'sd8192;
            5'd18:   v = 33'sd4096;
            5'd19:   v = 33'sd2048;
            5'd20:   v = 33'sd1024;
            5'd21:   v = 33'sd512;
            5'd22:   v = 33'sd256;
            5'd23:   v = 33'sd128;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
        logic signed [23:0] r;
        if (v > 40'sh00_007F_FFFF)
            r = 24'sh7F_FFFF;
        else if (v < -40'sh00_0080_0000)
            r = 24'sh80_0000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

@@ hdl/weo_front.sv @@
module weo_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  left_delta,
    input  logic signed [15:0]  right_delta,
    output logic                pop_valid,
    input  logic                pop_ready,
    output weo_pkg::weo_item_t  pop_item
);
    import weo_pkg::*;

    weo_item_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    weo_item_t  item;

    assign in_ready  = (cnt_reg != 2'd2);
    assign pop_valid = (cnt_reg != 2'd0);
    assign pop_item  = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        item.sum  = 17'(left_delta) + 17'(right_delta);
        item.diff = 17'(right_delta) - 17'(left_delta);
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= item;
    end

endmodule

@@ hdl/weo_back.sv @@
module weo_back #(
    parameter int CORDIC_STEPS = weo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  weo_pkg::weo_item_t  pop_item,
    input  logic [15:0]         radius,
    input  logic [15:0]         inverse_axle_length,
    input  logic [17:0]         steps_per_second,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [15:0]  heading_angle,
    output logic signed [23:0]  forward_speed,
    output logic signed [23:0]  turn_rate
);
    import weo_pkg::*;

    localparam int CNT_W = $clog2(CORDIC_STEPS);

    weo_state_t         st_reg, st_next;
    weo_item_t          item_reg;
    logic signed [33:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [59:0] mul_reg;
    logic signed [32:0] travel_reg;
    logic signed [49:0] dtheta_reg;
    logic signed [32:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [26:0]        wv_reg;
    logic [3:0]         wk_reg;
    logic signed [31:0] xacc_reg, yacc_reg;
    logic signed [15:0] hacc_reg;
    logic signed [23:0] fs_reg, tr_reg;
    logic               ov_reg, ov_next;
    logic signed [31:0] ox_reg, oy_reg;
    logic signed [15:0] oh_reg;
    logic signed [23:0] ofs_reg, otr_reg;

    logic signed [60:0] mul_ext;
    logic signed [25:0] c24, s24;
    logic signed [32:0] ysh, xsh, atan_v;
    logic signed [15:0] hf;
    logic signed [33:0] rd16;
    logic signed [60:0] wsum;
    logic [26:0]        wsub;
    logic               last_iter;
    logic               out_free;

    assign out_free  = !ov_reg || out_ready;
    assign pop_ready = (st_reg == ST_IDLE);
    assign last_iter = (cnt_reg == CNT_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:   if (pop_valid) st_next = ST_TRAVEL;
            ST_TRAVEL: st_next = ST_DPROD;
            ST_DPROD:  st_next = ST_DTHETA;
            ST_DTHETA: st_next = ST_LOADD;
            ST_LOADD:  st_next = ST_CORDIC;
            ST_CORDIC: if (last_iter) st_next = ST_POSX;
            ST_POSX:   st_next = ST_POSY;
            ST_POSY:   st_next = ST_FSPD;
            ST_FSPD:   st_next = ST_TRATE;
            ST_TRATE:  st_next = ST_TRCAP;
            ST_TRCAP:  st_next = ST_WRAP;
            ST_WRAP:   if (wk_reg == 4'd0) st_next = ST_DONE;
            ST_DONE:   if (out_free) st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (st_reg == ST_DONE && out_free)
            ov_next = 1'b1;
        else if (ov_reg && out_ready)
            ov_next = 1'b0;
        else
            ov_next = ov_reg;
    end

    always_comb
    begin
        mul_ext = {mul_reg[59], mul_reg};
        c24  = 26'((33'(cx_reg) + 33'sd32) >>> 6);
        s24  = 26'((33'(cy_reg) + 33'sd32) >>> 6);
        if (flip_reg)
        begin
            c24 = -c24;
            s24 = -s24;
        end
        rd16 = 34'(({dtheta_reg[49], dtheta_reg} + 51'sd32768) >>> 16);
        mul_a = '0;
        mul_b = '0;
        unique case (st_reg)
            ST_TRAVEL:
            begin
                mul_a = 34'(item_reg.sum);
                mul_b = 26'({1'b0, radius});
            end
            ST_DPROD:
            begin
                mul_a = 34'(item_reg.diff);
                mul_b = 26'({1'b0, radius});
            end
            ST_DTHETA:
            begin
                mul_a = mul_reg[33:0];
                mul_b = 26'({1'b0, inverse_axle_length});
            end
            ST_POSX:
            begin
                mul_a = 34'(travel_reg);
                mul_b = c24;
            end
            ST_POSY:
            begin
                mul_a = 34'(travel_reg);
                mul_b = s24;
            end
            ST_FSPD:
            begin
                mul_a = 34'(travel_reg);
                mul_b = 26'({1'b0, steps_per_second});
            end
            ST_TRATE:
            begin
                mul_a = rd16;
                mul_b = 26'({1'b0, steps_per_second});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        ysh    = cy_reg >>> cnt_reg;
        xsh    = cx_reg >>> cnt_reg;
        atan_v = atan_q30(ATAN_IDX_W'(cnt_reg));
        if (hacc_reg > HALF_PI_Q13)
            hf = hacc_reg - PI_Q13;
        else if (hacc_reg < -HALF_PI_Q13)
            hf = hacc_reg + PI_Q13;
        else
            hf = hacc_reg;
        wsum = ((mul_ext + (61'sd1 <<< 22)) >>> 23) + 61'(hacc_reg) + 61'(PI_Q13)
               + 61'(TWO_PI_Q13 << WRAP_TOP);
        wsub = TWO_PI_Q13 << wk_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            xacc_reg <= '0;
            yacc_reg <= '0;
            hacc_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            unique case (st_reg)
                ST_POSX: ;
                ST_POSY:
                    xacc_reg <= sat32(34'(xacc_reg) + 34'((mul_ext + (61'sd1 <<< 36)) >>> 37));
                ST_FSPD:
                    yacc_reg <= sat32(34'(yacc_reg) + 34'((mul_ext + (61'sd1 <<< 36)) >>> 37));
                ST_DONE:
                    if (out_free)
                        hacc_reg <= 16'(wv_reg) + NEG_PI_Q13;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        unique case (st_reg)
            ST_IDLE:
                if (pop_valid) item_reg <= pop_item;
            ST_DPROD:
                travel_reg <= mul_reg[32:0];
            ST_LOADD:
            begin
                dtheta_reg <= mul_reg[49:0];
                wv_reg     <= wsum[26:0];
                wk_reg     <= WRAP_TOP;
                cx_reg     <= CORDIC_X0;
                cy_reg     <= '0;
                cz_reg     <= 33'(hf) * 33'sd131072;
                flip_reg   <= (hacc_reg > HALF_PI_Q13) || (hacc_reg < -HALF_PI_Q13);
                cnt_reg    <= '0;
            end
            ST_CORDIC:
            begin
                if (!cz_reg[32])
                begin
                    cx_reg <= cx_reg - ysh;
                    cy_reg <= cy_reg + xsh;
                    cz_reg <= cz_reg - atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg + ysh;
                    cy_reg <= cy_reg - xsh;
                    cz_reg <= cz_reg + atan_v;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_TRATE:
                fs_reg <= sat24(40'((mul_ext + (61'sd1 <<< 20)) >>> 21));
            ST_TRCAP:
                tr_reg <= sat24(40'((mul_ext + (61'sd1 <<< 13)) >>> 14));
            ST_WRAP:
            begin
                if (wv_reg >= wsub)
                    wv_reg <= wv_reg - wsub;
                if (wk_reg != 4'd0)
                    wk_reg <= wk_reg - 4'd1;
            end
            ST_DONE:
                if (out_free)
                begin
                    ox_reg  <= xacc_reg;
                    oy_reg  <= yacc_reg;
                    oh_reg  <= 16'(wv_reg) + NEG_PI_Q13;
                    ofs_reg <= fs_reg;
                    otr_reg <= tr_reg;
                end
            default: ;
        endcase
    end

    assign out_valid     = ov_reg;
    assign pos_x         = ox_reg;
    assign pos_y         = oy_reg;
    assign heading_angle = oh_reg;
    assign forward_speed = ofs_reg;
    assign turn_rate     = otr_reg;

endmodule

@@ hdl/wheel_encoder_odometry_core.sv @@
// the single sequencer takes no new beat until it is done with the last; it runs
// the shared multiplier, the CORDIC loop and the heading wrap in turn
// a two-beat queue takes input while the sequencer works
// reset clears pose to zero and loads the default radius, axle and rate registers
module wheel_encoder_odometry_core #(
    parameter int CORDIC_STEPS = weo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [17:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  left_delta,
    input  logic signed [15:0]  right_delta,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [15:0]  heading_angle,
    output logic signed [23:0]  forward_speed,
    output logic signed [23:0]  turn_rate
);
    import weo_pkg::*;

    logic [15:0] radius_reg;
    logic [15:0] inv_axle_reg;
    logic [17:0] sps_reg;
    logic        pop_valid, pop_ready;
    weo_item_t   pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= RADIUS_RST;
            inv_axle_reg <= INV_AXLE_RST;
            sps_reg      <= STEPS_PER_S_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS:       radius_reg   <= cfg_data[15:0];
                REG_INV_AXLE:     inv_axle_reg <= cfg_data[15:0];
                REG_STEPS_PER_S:  sps_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    weo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .left_delta  (left_delta),
        .right_delta (right_delta),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item)
    );

    weo_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .pop_valid           (pop_valid),
        .pop_ready           (pop_ready),
        .pop_item            (pop_item),
        .radius              (radius_reg),
        .inverse_axle_length (inv_axle_reg),
        .steps_per_second    (sps_reg),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .pos_x               (pos_x),
        .pos_y               (pos_y),
        .heading_angle       (heading_angle),
        .forward_speed       (forward_speed),
        .turn_rate           (turn_rate)
    );

`ifndef NO_ASSERTIONS
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading_angle >= NEG_PI_Q13) && (heading_angle < PI_Q13))
        else $error("heading outside wrap range");

    a_full_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> pop_valid)
        else $error("queue full without pending item");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |=> !pop_ready)
        else $error("sequencer took a second item while busy");
`endif

endmodule
